[hdl/k_way_merge_min_select_assert.svh]
// ----------------------------------------------------------------------------
// k-way merge assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_MIN_SELECT_ASSERT_SVH
`define K_WAY_MERGE_MIN_SELECT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define KWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// shared constants, command/status bundles and helpers of the k-way merge
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

	localparam int MAX_WAYS   = 8;
	localparam int VALUE_BITS = 31;
	localparam int CFG_BITS   = 4;

	// lane index width, also the number of comparator tree levels
	localparam int LANE_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LEVELS    = LANE_BITS;
	localparam int CAND_N    = 1 << LEVELS;
	// lane counter must hold MAX_WAYS itself
	localparam int CNT_BITS  = $clog2(MAX_WAYS + 1);
	localparam int LVL_BITS  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	localparam logic [LVL_BITS-1:0] LAST_LVL   = LVL_BITS'(LEVELS - 1);
	localparam logic [CFG_BITS-1:0] WAYS_RESET = CFG_BITS'(8);

	typedef struct packed {
		logic take;    // input beat accepted this cycle
		logic step;    // one comparator tree level
		logic finish;  // last level into the output register
	} kwm_ctl_t;

	typedef struct packed {
		logic has_result;  // current input beat produces a result
		logic out_busy;    // output register full and stalled
	} kwm_stat_t;

	// clamp the ways register to 1..MAX_WAYS
	function automatic logic [CNT_BITS-1:0] active_ways(input logic [CFG_BITS-1:0] cfg);
		logic [CNT_BITS-1:0] w;
		if (cfg == '0) begin
			w = CNT_BITS'(1);
		end else if (int'(cfg) > MAX_WAYS) begin
			w = CNT_BITS'(MAX_WAYS);
		end else begin
			w = CNT_BITS'(cfg);
		end
		return w;
	endfunction

endpackage

`default_nettype wire

[hdl/k_way_merge_min_select.sv]
// ----------------------------------------------------------------------------
// k_way_merge_min_select
// k-way merge engine: holds one head per sorted stream and picks the minimum
// ----------------------------------------------------------------------------
// Load beats (cmd 0) fill the lane heads in order; a refill beat (cmd 1)
// replaces the head of the lane that won last. After the final load and after
// every refill one result comes out: the smallest live head and its lane (the
// highest lane wins ties), or done_res when every lane is exhausted. Beats that
// produce no result are taken without a stall. A beat that produces a result
// holds in_stall high while the minimum is found by one comparator tree level
// per cycle, folding the candidate registers in place, with the last level
// written straight into the output register. That last step waits for as long
// as the previous result is still stalled at the output. The output register
// lets a new beat be accepted while a result is still stalled. ways_in_use
// may only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module k_way_merge_min_select (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kwm_pkg::CFG_BITS-1:0]   ways_in_use,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [kwm_pkg::VALUE_BITS-1:0] value,
	input  logic                           stream_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [kwm_pkg::VALUE_BITS-1:0] merged_value,
	output logic [kwm_pkg::LANE_BITS-1:0]  min_lane,
	output logic                           done_res
);

	kwm_pkg::kwm_ctl_t  ctl;
	kwm_pkg::kwm_stat_t stat;

	kwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	kwm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.ways_in_use  (ways_in_use),
		.cmd          (cmd),
		.value        (value),
		.stream_end   (stream_end),
		.ctl          (ctl),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.merged_value (merged_value),
		.min_lane     (min_lane),
		.done_res     (done_res)
	);

endmodule

`default_nettype wire

[hdl/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl
// sequencer: accepts beats, walks the comparator tree levels, hands off result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "k_way_merge_min_select_assert.svh"

module kwm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  kwm_pkg::kwm_stat_t  stat,
	output kwm_pkg::kwm_ctl_t   ctl
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_REDUCE = 1'b1;

	logic                         state_q;
	logic                         state_d;
	logic [kwm_pkg::LVL_BITS-1:0] lvl_q;
	logic [kwm_pkg::LVL_BITS-1:0] lvl_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		lvl_d   = lvl_q;
		case (state_q)
			ST_IDLE: begin
				ctl.take = in_valid;
				if (in_valid && stat.has_result) begin
					state_d = ST_REDUCE;
					lvl_d   = '0;
				end
			end
			ST_REDUCE: begin
				if (lvl_q != kwm_pkg::LAST_LVL) begin
					ctl.step = 1'b1;
					lvl_d    = lvl_q + 1'b1;
				end else if (!stat.out_busy) begin
					// last compare goes straight into the output register
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= '0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
		end
	end

	`KWM_ASSERT_NEXT(a_result_starts_tree, ctl.take && stat.has_result, state_q == ST_REDUCE && lvl_q == '0, "result beat did not start the tree walk")
	`KWM_ASSERT_NOW(a_one_command, 1'b1, $onehot0(ctl), "more than one datapath command at once")

endmodule

`default_nettype wire

[hdl/kwm_dp.sv]
// ----------------------------------------------------------------------------
// kwm_dp
// lane heads, live flags, load counter, folding min tree and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "k_way_merge_min_select_assert.svh"

module kwm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kwm_pkg::CFG_BITS-1:0]     ways_in_use,
	input  logic                             cmd,
	input  logic [kwm_pkg::VALUE_BITS-1:0]   value,
	input  logic                             stream_end,
	input  kwm_pkg::kwm_ctl_t                ctl,
	output kwm_pkg::kwm_stat_t               stat,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [kwm_pkg::VALUE_BITS-1:0]   merged_value,
	output logic [kwm_pkg::LANE_BITS-1:0]    min_lane,
	output logic                             done_res
);

	typedef struct packed {
		logic                           valid;
		logic [kwm_pkg::VALUE_BITS-1:0] val;
		logic [kwm_pkg::LANE_BITS-1:0]  lane;
	} kwm_cand_t;

	// upper entry covers higher lanes, so it wins ties
	function automatic kwm_cand_t pick(input kwm_cand_t lo, input kwm_cand_t hi);
		kwm_cand_t r;
		if (hi.valid && (!lo.valid || hi.val <= lo.val)) begin
			r = hi;
		end else begin
			r = lo;
		end
		return r;
	endfunction

	logic [kwm_pkg::CFG_BITS-1:0]   ways_q;
	logic [kwm_pkg::VALUE_BITS-1:0] head_q [kwm_pkg::MAX_WAYS];
	logic [kwm_pkg::MAX_WAYS-1:0]   live_q;
	logic [kwm_pkg::CNT_BITS-1:0]   load_count_q;
	logic [kwm_pkg::LANE_BITS-1:0]  last_winner_q;
	kwm_cand_t                      cand_q [kwm_pkg::CAND_N];
	logic                           out_valid_q;
	logic [kwm_pkg::VALUE_BITS-1:0] merged_value_q;
	logic [kwm_pkg::LANE_BITS-1:0]  min_lane_q;
	logic                           done_q;

	logic [kwm_pkg::CNT_BITS-1:0]   ways;
	logic [kwm_pkg::MAX_WAYS-1:0]   way_mask;
	logic [kwm_pkg::MAX_WAYS-1:0]   live_nx;
	logic                           loads_done;
	logic                           load_ok;
	logic                           load_last;
	logic                           refill_ok;
	logic                           any_live;
	logic                           wr_en;
	logic [kwm_pkg::LANE_BITS-1:0]  wr_lane;
	kwm_cand_t                      cand_init [kwm_pkg::CAND_N];
	kwm_cand_t                      cand_red [kwm_pkg::CAND_N/2];
	kwm_cand_t                      top;

	assign cfg_ready = 1'b1;

	always_comb begin
		ways = kwm_pkg::active_ways(ways_q);
		for (int i = 0; i < kwm_pkg::MAX_WAYS; i++) begin
			way_mask[i] = (kwm_pkg::CNT_BITS'(i) < ways);
		end
		loads_done = (load_count_q >= ways);
		load_ok    = !cmd && !loads_done;
		load_last  = load_ok && ((load_count_q + 1'b1) == ways);
		refill_ok  = cmd && loads_done;
		any_live   = |(live_q & way_mask);
		// once every lane is dead a refill leaves the heads alone
		wr_en      = load_ok || (refill_ok && any_live);
		wr_lane    = cmd ? last_winner_q : load_count_q[kwm_pkg::LANE_BITS-1:0];
		live_nx    = live_q;
		if (wr_en) begin
			live_nx[wr_lane] = !stream_end;
		end
	end

	// tree leaves, with the beat being written bypassed in
	always_comb begin
		for (int i = 0; i < kwm_pkg::CAND_N; i++) begin
			cand_init[i] = '0;
		end
		for (int i = 0; i < kwm_pkg::MAX_WAYS; i++) begin
			cand_init[i].valid = live_nx[i] && way_mask[i];
			cand_init[i].val   = (wr_en && wr_lane == kwm_pkg::LANE_BITS'(i)) ? value : head_q[i];
			cand_init[i].lane  = kwm_pkg::LANE_BITS'(i);
		end
	end

	always_comb begin
		for (int i = 0; i < kwm_pkg::CAND_N/2; i++) begin
			cand_red[i] = pick(cand_q[2*i], cand_q[2*i+1]);
		end
		top = cand_red[0];
	end

	assign stat.has_result = load_last || refill_ok;
	assign stat.out_busy   = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q        <= kwm_pkg::WAYS_RESET;
			live_q        <= '0;
			load_count_q  <= '0;
			last_winner_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ways_q <= ways_in_use;
			end
			if (ctl.take) begin
				live_q <= live_nx;
				if (load_ok) begin
					load_count_q <= load_count_q + 1'b1;
				end
			end
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
				if (top.valid) begin
					last_winner_q <= top.lane;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take && wr_en) begin
			head_q[wr_lane] <= value;
		end
		if (ctl.take && stat.has_result) begin
			cand_q <= cand_init;
		end else if (ctl.step) begin
			for (int i = 0; i < kwm_pkg::CAND_N/2; i++) begin
				cand_q[i] <= cand_red[i];
			end
		end
		if (ctl.finish) begin
			merged_value_q <= top.valid ? top.val : '0;
			min_lane_q     <= top.valid ? top.lane : '0;
			done_q         <= !top.valid;
		end
	end

	assign out_valid    = out_valid_q;
	assign merged_value = merged_value_q;
	assign min_lane     = min_lane_q;
	assign done_res     = done_q;

	`KWM_ASSERT_NEXT(a_finish_fills_out, ctl.finish, out_valid_q, "finished compare did not fill the output register")
	`KWM_ASSERT_NEXT(a_winner_tracks_out, ctl.finish && top.valid, last_winner_q == min_lane_q && !done_q, "winner lane and reported lane disagree")

endmodule

`default_nettype wire
